>>> rtl/core/cpc_pkg.sv
// Shared types, constants and register codes of the cascaded position controller.
// Used by every file under rtl/core; depends on nothing else.
package cpc_pkg;

    localparam int SIG_W   = 32;                 // signed Q16.16 signals
    localparam int GAIN_W  = 16;                 // unsigned gains
    localparam int LIM_W   = 31;                 // unsigned limits
    localparam int RATE_W  = 10;                 // tick rate
    localparam int MUL_A_W = SIG_W + RATE_W;     // widest multiplicand: change times rate
    localparam int MUL_P_W = MUL_A_W + GAIN_W;   // widest product
    localparam int SUM_W   = MUL_P_W + 1;        // sum of the two inner loop products
    localparam int MAX_AXES = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int DEF_GAIN_FRAC_BITS = 8;
    localparam int DEF_AXES           = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POSITION_GAIN   = 3'd0,
        REG_VELOCITY_GAIN   = 3'd1,
        REG_DERIVATIVE_GAIN = 3'd2,
        REG_VELOCITY_LIMIT  = 3'd3,
        REG_ACCEL_LIMIT     = 3'd4,
        REG_TICK_RATE       = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [SIG_W-1:0] target_x;
        logic signed [SIG_W-1:0] target_y;
        logic signed [SIG_W-1:0] target_z;
        logic signed [SIG_W-1:0] pos_x;
        logic signed [SIG_W-1:0] pos_y;
        logic signed [SIG_W-1:0] pos_z;
        logic signed [SIG_W-1:0] speed_x;
        logic signed [SIG_W-1:0] speed_y;
        logic signed [SIG_W-1:0] speed_z;
    } t_in;

    typedef struct packed {
        logic signed [SIG_W-1:0] accel_x;
        logic signed [SIG_W-1:0] accel_y;
        logic signed [SIG_W-1:0] accel_z;
    } t_out;

    typedef struct packed {
        logic [GAIN_W-1:0] position_gain;
        logic [GAIN_W-1:0] velocity_gain;
        logic [GAIN_W-1:0] derivative_gain;
        logic [LIM_W-1:0]  velocity_limit;
        logic [LIM_W-1:0]  accel_limit;
        logic [RATE_W-1:0] tick_rate;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PERR,
        S_MULP_GO,
        S_MULP_WAIT,
        S_VCMD,
        S_VERR,
        S_CHG,
        S_MULV_GO,
        S_MULV_WAIT,
        S_MULR_GO,
        S_MULR_WAIT,
        S_MULD_GO,
        S_MULD_WAIT,
        S_ACC,
        S_DONE
    } t_state;

endpackage

>>> rtl/core/cpc_cfg.sv
// Configuration register file of the cascaded position controller.
// Depends on cpc_pkg for the register codes and the t_cfg struct.
module cpc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [cpc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cpc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                             o_cfg_ready,
    output cpc_pkg::t_cfg                    o_cfg
);
    import cpc_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Writes to an index outside the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.position_gain   <= GAIN_W'(243);
            r_cfg.velocity_gain   <= GAIN_W'(461);
            r_cfg.derivative_gain <= GAIN_W'(102);
            r_cfg.velocity_limit  <= LIM_W'(196608);
            r_cfg.accel_limit     <= LIM_W'(327680);
            r_cfg.tick_rate       <= RATE_W'(50);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_POSITION_GAIN:   r_cfg.position_gain   <= i_cfg_data[GAIN_W-1:0];
                REG_VELOCITY_GAIN:   r_cfg.velocity_gain   <= i_cfg_data[GAIN_W-1:0];
                REG_DERIVATIVE_GAIN: r_cfg.derivative_gain <= i_cfg_data[GAIN_W-1:0];
                REG_VELOCITY_LIMIT:  r_cfg.velocity_limit  <= i_cfg_data[LIM_W-1:0];
                REG_ACCEL_LIMIT:     r_cfg.accel_limit     <= i_cfg_data[LIM_W-1:0];
                REG_TICK_RATE:       r_cfg.tick_rate       <= i_cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/core/cpc_smul.sv
// Bit-serial shift-and-add multiplier: signed multiplicand times unsigned multiplier,
// one multiplier bit per cycle. Depends on cpc_pkg for the operand widths.
module cpc_smul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [cpc_pkg::MUL_A_W-1:0]      i_a,
    input  logic [cpc_pkg::GAIN_W-1:0]       i_b,
    output logic                             o_done,
    output logic [cpc_pkg::MUL_P_W-1:0]      o_prod
);
    import cpc_pkg::*;

    localparam int CNT_W = $clog2(GAIN_W + 1);

    logic [MUL_P_W-1:0] r_mcand;
    logic [GAIN_W-1:0]  r_mplier;
    logic [MUL_P_W-1:0] r_acc;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    assign o_done = r_done;
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(GAIN_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The multiplicand is sign-extended to the product width, so the
    // sum modulo 2^MUL_P_W is the exact signed product.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= {{(MUL_P_W - MUL_A_W){i_a[MUL_A_W-1]}}, i_a};
            r_mplier <= i_b;
            r_acc    <= '0;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[MUL_P_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[GAIN_W-1:1]};
        end
    end

endmodule

>>> rtl/core/cpc_engine.sv
// Per-axis sequencer and datapath of the cascaded position controller.
// Depends on cpc_pkg and on cpc_smul for all four products.
module cpc_engine #(
    parameter int GAIN_FRAC_BITS = cpc_pkg::DEF_GAIN_FRAC_BITS,
    parameter int AXES           = cpc_pkg::DEF_AXES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  cpc_pkg::t_in          i_in,
    input  cpc_pkg::t_cfg         i_cfg,
    input  logic                  i_take,
    output cpc_pkg::t_eng_stat    o_stat,
    output cpc_pkg::t_out         o_res
);
    import cpc_pkg::*;

    localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;

    t_state r_state;
    t_state n_state;

    logic [AXW-1:0]          r_axis;
    logic [1:0]              w_ax;
    t_in                     r_in;
    t_out                    r_res;
    logic signed [SIG_W-1:0] r_last [AXES];
    logic signed [SIG_W-1:0] r_perr;
    logic signed [SIG_W-1:0] r_vcmd;
    logic signed [SIG_W-1:0] r_verr;
    logic signed [SIG_W-1:0] r_chg;
    logic [MUL_P_W-1:0]      r_pv;
    logic signed [SUM_W-1:0] r_sum;

    logic signed [SIG_W-1:0] w_target;
    logic signed [SIG_W-1:0] w_pos;
    logic signed [SIG_W-1:0] w_speed;
    logic signed [SUM_W-1:0] w_prod_ext;
    logic signed [SUM_W-1:0] w_vcmd_full;
    logic signed [SUM_W-1:0] w_acc_full;
    logic signed [SIG_W-1:0] w_acc;
    logic                    w_last_axis;

    logic                    w_mul_start;
    logic [MUL_A_W-1:0]      w_mul_a;
    logic [GAIN_W-1:0]       w_mul_b;
    logic                    w_mul_done;
    logic [MUL_P_W-1:0]      w_mul_prod;

    // Saturates a 33 bit difference to the 32 bit signed range.
    function automatic logic signed [SIG_W-1:0] sat32(input logic [SIG_W:0] v);
        logic signed [SIG_W-1:0] r;
        if (v[SIG_W] != v[SIG_W-1]) begin
            r = v[SIG_W] ? {1'b1, {(SIG_W-1){1'b0}}} : {1'b0, {(SIG_W-1){1'b1}}};
        end else begin
            r = v[SIG_W-1:0];
        end
        return r;
    endfunction

    // Symmetric clamp to plus or minus an unsigned limit.
    function automatic logic signed [SIG_W-1:0] clamp_sym(input logic signed [SUM_W-1:0] v,
                                                          input logic [LIM_W-1:0] lim);
        logic signed [SUM_W-1:0] l;
        logic signed [SUM_W-1:0] r;
        l = {{(SUM_W-LIM_W){1'b0}}, lim};
        if (v > l) begin
            r = l;
        end else if (v < -l) begin
            r = -l;
        end else begin
            r = v;
        end
        return r[SIG_W-1:0];
    endfunction

    cpc_smul u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    assign w_ax        = 2'(r_axis);
    assign w_last_axis = (r_axis == AXW'(AXES - 1));

    always_comb begin
        case (w_ax)
            2'd0: begin
                w_target = r_in.target_x;
                w_pos    = r_in.pos_x;
                w_speed  = r_in.speed_x;
            end
            2'd1: begin
                w_target = r_in.target_y;
                w_pos    = r_in.pos_y;
                w_speed  = r_in.speed_y;
            end
            default: begin
                w_target = r_in.target_z;
                w_pos    = r_in.pos_z;
                w_speed  = r_in.speed_z;
            end
        endcase
    end

    // Floor of a product by 2^GAIN_FRAC_BITS is an arithmetic right shift.
    assign w_prod_ext  = {w_mul_prod[MUL_P_W-1], w_mul_prod};
    assign w_vcmd_full = w_prod_ext >>> GAIN_FRAC_BITS;
    assign w_acc_full  = r_sum >>> GAIN_FRAC_BITS;
    assign w_acc       = clamp_sym(w_acc_full, i_cfg.accel_limit);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_start) n_state = S_PERR;
            S_PERR:      n_state = S_MULP_GO;
            S_MULP_GO:   n_state = S_MULP_WAIT;
            S_MULP_WAIT: if (w_mul_done) n_state = S_VCMD;
            S_VCMD:      n_state = S_VERR;
            S_VERR:      n_state = S_CHG;
            S_CHG:       n_state = S_MULV_GO;
            S_MULV_GO:   n_state = S_MULV_WAIT;
            S_MULV_WAIT: if (w_mul_done) n_state = S_MULR_GO;
            S_MULR_GO:   n_state = S_MULR_WAIT;
            S_MULR_WAIT: if (w_mul_done) n_state = S_MULD_GO;
            S_MULD_GO:   n_state = S_MULD_WAIT;
            S_MULD_WAIT: if (w_mul_done) n_state = S_ACC;
            S_ACC:       n_state = w_last_axis ? S_DONE : S_PERR;
            S_DONE:      if (i_take) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_mul_start = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        o_stat.busy = (r_state != S_IDLE);
        o_stat.done = 1'b0;
        unique case (r_state)
            S_MULP_GO: begin
                w_mul_start = 1'b1;
                w_mul_a     = MUL_A_W'(r_perr);
                w_mul_b     = i_cfg.position_gain;
            end
            S_MULV_GO: begin
                w_mul_start = 1'b1;
                w_mul_a     = MUL_A_W'(r_verr);
                w_mul_b     = i_cfg.velocity_gain;
            end
            S_MULR_GO: begin
                w_mul_start = 1'b1;
                w_mul_a     = MUL_A_W'(r_chg);
                w_mul_b     = GAIN_W'(i_cfg.tick_rate);
            end
            S_MULD_GO: begin
                w_mul_start = 1'b1;
                w_mul_a     = w_mul_prod[MUL_A_W-1:0];
                w_mul_b     = i_cfg.derivative_gain;
            end
            S_DONE: begin
                o_stat.done = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= '0;
            for (int i = 0; i < AXES; i++) begin
                r_last[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_axis <= '0;
            end else if (r_state == S_ACC) begin
                r_last[r_axis] <= r_verr;
                if (!w_last_axis) begin
                    r_axis <= r_axis + AXW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_in  <= i_in;
                    r_res <= '0;
                end
            end
            S_PERR: r_perr <= sat32({w_target[SIG_W-1], w_target} - {w_pos[SIG_W-1], w_pos});
            S_VCMD: r_vcmd <= clamp_sym(w_vcmd_full, i_cfg.velocity_limit);
            S_VERR: r_verr <= sat32({r_vcmd[SIG_W-1], r_vcmd} - {w_speed[SIG_W-1], w_speed});
            S_CHG:  r_chg  <= sat32({r_verr[SIG_W-1], r_verr}
                                    - {r_last[r_axis][SIG_W-1], r_last[r_axis]});
            S_MULV_WAIT: begin
                if (w_mul_done) begin
                    r_pv <= w_mul_prod;
                end
            end
            S_MULD_WAIT: begin
                if (w_mul_done) begin
                    r_sum <= {r_pv[MUL_P_W-1], r_pv} + {w_mul_prod[MUL_P_W-1], w_mul_prod};
                end
            end
            S_ACC: begin
                case (w_ax)
                    2'd0:    r_res.accel_x <= w_acc;
                    2'd1:    r_res.accel_y <= w_acc;
                    default: r_res.accel_z <= w_acc;
                endcase
            end
            default: ;
        endcase
    end

    assign o_res = r_res;

endmodule

>>> rtl/core/cascaded_pd_position_controller_top.sv
// Top level of the cascaded P/PD position and velocity controller.
// Depends on cpc_pkg, cpc_cfg, cpc_engine and, through the engine, cpc_smul.

// One input transaction is one control tick carrying target position, measured
// position and measured velocity on each axis; it yields exactly one output
// transaction with the commanded acceleration per axis. Each axis runs an outer
// proportional loop (position error times position_gain, clamped to the velocity
// limit) and an inner PD loop (velocity error times velocity_gain plus
// derivative_gain times the error change times tick_rate, clamped to the
// acceleration limit). Gain products round toward minus infinity and differences
// saturate to 32 bits. The previous velocity error of each axis is kept between
// ticks and cleared by reset. Axes are processed one after another, and each axis
// uses a bit-serial multiplier four times. The next tick is taken as soon as the engine
// has moved its result to the output register, even if that result is still waiting
// to be taken. Axes beyond AXES report zero acceleration.
// Configuration writes are always ready and must be made while no tick is in flight.
module cascaded_pd_position_controller_top #(
    parameter int GAIN_FRAC_BITS = cpc_pkg::DEF_GAIN_FRAC_BITS,
    parameter int AXES           = cpc_pkg::DEF_AXES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Tick input channel.
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  cpc_pkg::t_in                    i_in,
    // Acceleration output channel.
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output cpc_pkg::t_out                   o_out,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cpc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cpc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cpc_pkg::*;

    t_cfg      w_cfg;
    t_eng_stat w_stat;
    t_out      w_res;
    logic      w_in_accept;
    logic      w_take;
    logic      r_out_valid;
    t_out      r_out;

    cpc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    // The engine is free for a new transaction whenever it is idle.
    assign o_in_stall  = w_stat.busy;
    assign w_in_accept = i_in_valid && !o_in_stall;

    // A finished result moves into the output register when that register is
    // empty or is being emptied in the same cycle.
    assign w_take = w_stat.done && (!r_out_valid || !i_out_stall);

    cpc_engine #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .AXES           (AXES)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_accept),
        .i_in    (i_in),
        .i_cfg   (w_cfg),
        .i_take  (w_take),
        .o_stat  (w_stat),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
